@@ design/intel_hex_record_parser_unit_defines.svh @@
// Assertion macros for the Intel HEX record parser.
// Each macro takes a label, an antecedent and a consequent and checks them
// on the rising edge of aclk while aresetn is high.
`ifndef INTEL_HEX_RECORD_PARSER_UNIT_DEFINES_SVH
`define INTEL_HEX_RECORD_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define IHRP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("intel_hex_record_parser_unit: assertion failed");
// Next-cycle implication.
`define IHRP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("intel_hex_record_parser_unit: assertion failed");
`else
`define IHRP_ASSERT_IMP(label, ante, cons)
`define IHRP_ASSERT_NXT(label, ante, cons)
`endif

`endif

@@ design/ihrp_pkg.sv @@
`timescale 1ns / 1ps

package ihrp_pkg;

    // Parser phase codes.
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_DATA   = 3'd2;
    localparam logic [2:0] PH_CHECK  = 3'd3;
    localparam logic [2:0] PH_GOT    = 3'd4;
    localparam logic [2:0] PH_EOF    = 3'd5;

    localparam logic [7:0] COLON_CHAR      = 8'h3A;
    localparam logic [2:0] HEADER_LAST_POS = 3'd7;  // eighth header digit
    localparam logic [7:0] REC_TYPE_EOF    = 8'h01;

    // One result word.
    typedef struct packed {
        logic        data_valid;
        logic [7:0]  data_byte;
        logic [7:0]  data_index;
        logic        record_done;
        logic        end_of_file;
        logic        checksum_ok;
        logic [7:0]  rec_length;
        logic [15:0] load_address;
        logic [7:0]  rec_type;
    } result_t;

    // ASCII hex digit to nibble; anything else reads as zero.
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [3:0] n;
        n = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            n = c[3:0];
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            n = 4'(c[2:0] + 3'd1) + 4'd8;
        end
        return n;
    endfunction

endpackage

@@ design/ihrp_core.sv @@
`timescale 1ns / 1ps

// Parser state and next-state logic; one character per step.
module ihrp_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  logic [7:0]           ch,
    output ihrp_pkg::result_t    result
);

    logic [2:0]  phase_reg, phase_next;
    logic [2:0]  digit_pos_reg, digit_pos_next;
    logic [7:0]  len_reg, len_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  byte_counter_reg, byte_counter_next;
    logic [3:0]  data_nibble_reg, data_nibble_next;
    logic [7:0]  rx_check_reg, rx_check_next;
    logic [7:0]  sum_acc_reg, sum_acc_next;
    logic        sum_phase_reg, sum_phase_next;
    logic [3:0]  sum_nibble_reg, sum_nibble_next;

    always_comb begin
        logic [3:0] v;
        logic [7:0] sum_neg;
        v       = ihrp_pkg::nibble_of(ch);
        sum_neg = 8'(8'd0 - sum_acc_reg);

        phase_next        = phase_reg;
        digit_pos_next    = digit_pos_reg;
        len_next          = len_reg;
        addr_next         = addr_reg;
        type_next         = type_reg;
        byte_counter_next = byte_counter_reg;
        data_nibble_next  = data_nibble_reg;
        rx_check_next     = rx_check_reg;
        sum_acc_next      = sum_acc_reg;
        sum_phase_next    = sum_phase_reg;
        sum_nibble_next   = sum_nibble_reg;

        result = '0;

        // Running byte sum over header and data digits.
        if (phase_reg == ihrp_pkg::PH_HEADER || phase_reg == ihrp_pkg::PH_DATA) begin
            if (!sum_phase_reg) begin
                sum_nibble_next = v;
                sum_phase_next  = 1'b1;
            end else begin
                sum_acc_next    = 8'(sum_acc_reg + {sum_nibble_reg, v});
                sum_phase_next  = 1'b0;
                sum_nibble_next = 4'd0;
            end
        end

        // A finished record clears everything before this character is parsed.
        if (phase_reg == ihrp_pkg::PH_GOT || phase_reg == ihrp_pkg::PH_EOF) begin
            digit_pos_next    = 3'd0;
            len_next          = 8'd0;
            addr_next         = 16'd0;
            type_next         = 8'd0;
            byte_counter_next = 8'd0;
            data_nibble_next  = 4'd0;
            rx_check_next     = 8'd0;
            sum_acc_next      = 8'd0;
            sum_phase_next    = 1'b0;
            sum_nibble_next   = 4'd0;
        end

        case (phase_reg)
            ihrp_pkg::PH_HEADER: begin
                if (digit_pos_reg < 3'd2) begin
                    len_next = {len_reg[3:0], v};
                end else if (digit_pos_reg < 3'd6) begin
                    addr_next = {addr_reg[11:0], v};
                end else begin
                    type_next = {type_reg[3:0], v};
                end
                digit_pos_next = 3'(digit_pos_reg + 3'd1);
                if (digit_pos_reg == ihrp_pkg::HEADER_LAST_POS) begin
                    phase_next     = (len_next != 8'd0) ? ihrp_pkg::PH_DATA
                                                        : ihrp_pkg::PH_CHECK;
                    digit_pos_next = 3'd0;
                end
            end
            ihrp_pkg::PH_DATA: begin
                if (digit_pos_reg == 3'd0) begin
                    data_nibble_next = v;
                    digit_pos_next   = 3'd1;
                end else begin
                    result.data_valid = 1'b1;
                    result.data_byte  = {data_nibble_reg, v};
                    result.data_index = byte_counter_reg;
                    digit_pos_next    = 3'd0;
                    data_nibble_next  = 4'd0;
                    byte_counter_next = 8'(byte_counter_reg + 8'd1);
                    if (byte_counter_next == len_reg) begin
                        phase_next = ihrp_pkg::PH_CHECK;
                    end
                end
            end
            ihrp_pkg::PH_CHECK: begin
                rx_check_next = {rx_check_reg[3:0], v};
                if (digit_pos_reg == 3'd0) begin
                    digit_pos_next = 3'd1;
                end else begin
                    sum_acc_next       = sum_neg;
                    result.record_done = 1'b1;
                    result.checksum_ok = (sum_neg == rx_check_next);
                    if (type_reg == ihrp_pkg::REC_TYPE_EOF) begin
                        phase_next         = ihrp_pkg::PH_EOF;
                        result.end_of_file = 1'b1;
                    end else begin
                        phase_next = ihrp_pkg::PH_GOT;
                    end
                end
            end
            default: begin
                // Idle, finished record, or unused code: wait for a colon.
                phase_next = ihrp_pkg::PH_IDLE;
                if (ch == ihrp_pkg::COLON_CHAR) begin
                    phase_next     = ihrp_pkg::PH_HEADER;
                    digit_pos_next = 3'd0;
                end
            end
        endcase

        result.rec_length   = len_next;
        result.load_address = addr_next;
        result.rec_type     = type_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= ihrp_pkg::PH_IDLE;
            digit_pos_reg    <= 3'd0;
            len_reg          <= 8'd0;
            addr_reg         <= 16'd0;
            type_reg         <= 8'd0;
            byte_counter_reg <= 8'd0;
            data_nibble_reg  <= 4'd0;
            rx_check_reg     <= 8'd0;
            sum_acc_reg      <= 8'd0;
            sum_phase_reg    <= 1'b0;
            sum_nibble_reg   <= 4'd0;
        end else if (step_en) begin
            phase_reg        <= phase_next;
            digit_pos_reg    <= digit_pos_next;
            len_reg          <= len_next;
            addr_reg         <= addr_next;
            type_reg         <= type_next;
            byte_counter_reg <= byte_counter_next;
            data_nibble_reg  <= data_nibble_next;
            rx_check_reg     <= rx_check_next;
            sum_acc_reg      <= sum_acc_next;
            sum_phase_reg    <= sum_phase_next;
            sum_nibble_reg   <= sum_nibble_next;
        end
    end

endmodule

@@ design/intel_hex_record_parser_unit.sv @@
// Intel HEX record parser: one ASCII character in, one result word out.
// The result for a character is registered and is on m_* in the cycle after it is accepted.
// Throughput: one character per cycle while the sink keeps m_ready high; the output
// register is refilled in the same cycle its word is taken, so ready stays high under a flowing sink.
// Reset: synchronous, active-low aresetn clears parser state (idle, all fields
// zero) and empties the output register.
`timescale 1ns / 1ps
`include "intel_hex_record_parser_unit_defines.svh"

module intel_hex_record_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,

    // Character input.
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,

    // Result output.
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_data_valid,
    output logic [7:0]  m_data_byte,
    output logic [7:0]  m_data_index,
    output logic        m_record_done,
    output logic        m_end_of_file,
    output logic        m_checksum_ok,
    output logic [7:0]  m_rec_length,
    output logic [15:0] m_load_address,
    output logic [7:0]  m_rec_type
);

    ihrp_pkg::result_t result;
    ihrp_pkg::result_t out_reg;
    logic              out_valid_reg;
    logic              accept;

    // Take a new character whenever the output slot is free or being drained.
    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // State machine: advances only on an accepted character.
    ihrp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (accept),
        .ch      (s_ch),
        .result  (result)
    );

    // Output register: valid flag is control, payload needs no reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= result;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_data_valid   = out_reg.data_valid;
    assign m_data_byte    = out_reg.data_byte;
    assign m_data_index   = out_reg.data_index;
    assign m_record_done  = out_reg.record_done;
    assign m_end_of_file  = out_reg.end_of_file;
    assign m_checksum_ok  = out_reg.checksum_ok;
    assign m_rec_length   = out_reg.rec_length;
    assign m_load_address = out_reg.load_address;
    assign m_rec_type     = out_reg.rec_type;

    // A data byte and a record end never complete on the same character.
    `IHRP_ASSERT_IMP(a_byte_not_done, m_valid, !(m_data_valid && m_record_done))
    // End of file and checksum status only come with a finished record.
    `IHRP_ASSERT_IMP(a_eof_needs_done, m_valid && m_end_of_file, m_record_done)
    `IHRP_ASSERT_IMP(a_ok_needs_done, m_valid && m_checksum_ok, m_record_done)
    // Every accepted character produces a word in the next cycle.
    `IHRP_ASSERT_NXT(a_accept_fills, s_valid && s_ready, m_valid)

endmodule

@@ tb/intel_hex_record_parser_unit_test.sv @@
`timescale 1ns / 1ps

module intel_hex_record_parser_unit_test;

    // Random part: stop once this many record characters have gone in.
    localparam int unsigned RECORD_CHAR_TARGET = 1400;
    // Watchdog: cycles without any word moving on either channel.
    localparam int unsigned IDLE_LIMIT = 2000;
    // Cycles to linger once every expected word has arrived.
    localparam int unsigned DRAIN_CYCLES = 4;

    localparam logic [7:0] ASCII_ZERO    = "0";
    localparam logic [7:0] ASCII_NINE    = "9";
    localparam logic [7:0] ASCII_UPPER_A = "A";
    localparam logic [7:0] ASCII_UPPER_F = "F";
    localparam logic [7:0] ASCII_LOWER_A = "a";
    localparam logic [7:0] ASCII_LOWER_F = "f";

    // Words that can be read straight off the record text.
    localparam ihrp_pkg::result_t IDLE_WORD = '0;
    localparam ihrp_pkg::result_t EOF_WORD = '{
        data_valid: 1'b0, data_byte: 8'h00, data_index: 8'h00,
        record_done: 1'b1, end_of_file: 1'b1, checksum_ok: 1'b1,
        rec_length: 8'h00, load_address: 16'h0000, rec_type: ihrp_pkg::REC_TYPE_EOF};
    localparam ihrp_pkg::result_t BYTE_WORD = '{
        data_valid: 1'b1, data_byte: 8'h05, data_index: 8'h00,
        record_done: 1'b0, end_of_file: 1'b0, checksum_ok: 1'b0,
        rec_length: 8'h01, load_address: 16'hFFFF, rec_type: 8'h00};
    localparam ihrp_pkg::result_t BAD_SUM_WORD = '{
        data_valid: 1'b0, data_byte: 8'h00, data_index: 8'h00,
        record_done: 1'b1, end_of_file: 1'b0, checksum_ok: 1'b0,
        rec_length: 8'h01, load_address: 16'hFFFF, rec_type: 8'h00};

    // One row of the directed table; fixed rows carry their own answer.
    typedef struct packed {
        logic [7:0]        ch;
        logic              fixed;
        ihrp_pkg::result_t want;
    } stim_row_t;

    // Shadow copy of the parser registers.
    typedef struct packed {
        logic [2:0]  phase;
        logic [2:0]  pos;
        logic [7:0]  len;
        logic [15:0] addr;
        logic [7:0]  typ;
        logic [7:0]  count;
        logic [3:0]  data_nib;
        logic [7:0]  rx_sum;
        logic [7:0]  acc;
        logic        pair_half;
        logic [3:0]  pair_nib;
    } parser_shadow_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_ch = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_data_valid;
    logic [7:0]  m_data_byte;
    logic [7:0]  m_data_index;
    logic        m_record_done;
    logic        m_end_of_file;
    logic        m_checksum_ok;
    logic [7:0]  m_rec_length;
    logic [15:0] m_load_address;
    logic [7:0]  m_rec_type;

    parser_shadow_t    shadow = '0;
    ihrp_pkg::result_t pending_results[$];
    stim_row_t         directed_rows[25];
    int unsigned       mismatch_count = 0;
    int unsigned       record_chars = 0;
    int unsigned       idle_cycles = 0;
    int unsigned       sink_stall_left = 0;
    logic              quiet = 1'b0;

    always #1 aclk = ~aclk;

    intel_hex_record_parser_unit u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_ch           (s_ch),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data_valid   (m_data_valid),
        .m_data_byte    (m_data_byte),
        .m_data_index   (m_data_index),
        .m_record_done  (m_record_done),
        .m_end_of_file  (m_end_of_file),
        .m_checksum_ok  (m_checksum_ok),
        .m_rec_length   (m_rec_length),
        .m_load_address (m_load_address),
        .m_rec_type     (m_rec_type)
    );

    // Decode an ASCII hex digit; anything else reads as zero.
    function automatic logic [3:0] hex_digit_value(input logic [7:0] c);
        if (c >= ASCII_ZERO && c <= ASCII_NINE) return 4'(c - ASCII_ZERO);
        if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_F) return 4'(c - ASCII_UPPER_A + 8'd10);
        if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_F) return 4'(c - ASCII_LOWER_A + 8'd10);
        return 4'd0;
    endfunction

    // Render a nibble as a hex digit, letters in random case.
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return ASCII_ZERO + 8'(n);
        return ($urandom_range(0, 1) ? ASCII_LOWER_A : ASCII_UPPER_A) + 8'(n) - 8'd10;
    endfunction

    // Advance the shadow parser by one character and return the word it owes.
    function automatic ihrp_pkg::result_t parse_char(input logic [7:0] c);
        logic [3:0]        v;
        ihrp_pkg::result_t r;
        v = hex_digit_value(c);
        r = '0;
        // Header and data digits pair up into the running byte sum.
        if (shadow.phase == ihrp_pkg::PH_HEADER || shadow.phase == ihrp_pkg::PH_DATA) begin
            if (!shadow.pair_half) begin
                shadow.pair_nib  = v;
                shadow.pair_half = 1'b1;
            end else begin
                shadow.acc       = shadow.acc + {shadow.pair_nib, v};
                shadow.pair_half = 1'b0;
                shadow.pair_nib  = 4'd0;
            end
        end
        // A finished record is wiped before the character is looked at.
        if (shadow.phase == ihrp_pkg::PH_GOT || shadow.phase == ihrp_pkg::PH_EOF) begin
            shadow = '0;
        end
        case (shadow.phase)
            ihrp_pkg::PH_HEADER: begin
                if (shadow.pos < 3'd2) begin
                    shadow.len = {shadow.len[3:0], v};
                end else if (shadow.pos < 3'd6) begin
                    shadow.addr = {shadow.addr[11:0], v};
                end else begin
                    shadow.typ = {shadow.typ[3:0], v};
                end
                if (shadow.pos == ihrp_pkg::HEADER_LAST_POS) begin
                    shadow.phase = (shadow.len != 8'd0) ? ihrp_pkg::PH_DATA
                                                        : ihrp_pkg::PH_CHECK;
                    shadow.pos   = 3'd0;
                end else begin
                    shadow.pos = shadow.pos + 3'd1;
                end
            end
            ihrp_pkg::PH_DATA: begin
                if (shadow.pos == 3'd0) begin
                    shadow.data_nib = v;
                    shadow.pos      = 3'd1;
                end else begin
                    r.data_valid    = 1'b1;
                    r.data_byte     = {shadow.data_nib, v};
                    r.data_index    = shadow.count;
                    shadow.pos      = 3'd0;
                    shadow.data_nib = 4'd0;
                    shadow.count    = shadow.count + 8'd1;
                    if (shadow.count == shadow.len) shadow.phase = ihrp_pkg::PH_CHECK;
                end
            end
            ihrp_pkg::PH_CHECK: begin
                shadow.rx_sum = {shadow.rx_sum[3:0], v};
                if (shadow.pos == 3'd0) begin
                    shadow.pos = 3'd1;
                end else begin
                    shadow.acc    = 8'd0 - shadow.acc;
                    r.record_done = 1'b1;
                    r.checksum_ok = (shadow.acc == shadow.rx_sum);
                    if (shadow.typ == ihrp_pkg::REC_TYPE_EOF) begin
                        shadow.phase  = ihrp_pkg::PH_EOF;
                        r.end_of_file = 1'b1;
                    end else begin
                        shadow.phase = ihrp_pkg::PH_GOT;
                    end
                end
            end
            default: begin
                // Idle: only a colon opens a record.
                shadow.phase = ihrp_pkg::PH_IDLE;
                if (c == ihrp_pkg::COLON_CHAR) begin
                    shadow.phase = ihrp_pkg::PH_HEADER;
                    shadow.pos   = 3'd0;
                end
            end
        endcase
        r.rec_length   = shadow.len;
        r.load_address = shadow.addr;
        r.rec_type     = shadow.typ;
        return r;
    endfunction

    // Gap length for either side: mostly none, some short, a few long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Present one character, book its expected word, hold until it is taken.
    task automatic send_char(input logic [7:0] c, input logic fixed,
                             input ihrp_pkg::result_t want);
        int unsigned       gap;
        ihrp_pkg::result_t predicted;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        predicted = parse_char(c);
        pending_results.push_back(fixed ? want : predicted);
        s_valid <= 1'b1;
        s_ch    <= c;
        do @(posedge aclk); while (!s_ready);
    endtask

    // One record: mostly well formed, sometimes with a bad checksum,
    // a mangled digit, or cut short so the next colon lands mid-record.
    task automatic send_record();
        logic [7:0]  rec_bytes[$];
        logic [7:0]  chars[$];
        logic [7:0]  csum;
        logic [15:0] addr;
        int unsigned len;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) len = $urandom_range(0, 8);
        else if (r < 98) len = $urandom_range(9, 32);
        else len = $urandom_range(0, 1) ? 255 : $urandom_range(33, 254);
        addr = 16'($urandom);
        rec_bytes.push_back(8'(len));
        rec_bytes.push_back(addr[15:8]);
        rec_bytes.push_back(addr[7:0]);
        r = $urandom_range(0, 99);
        if (r < 50) rec_bytes.push_back(8'h00);
        else if (r < 65) rec_bytes.push_back(ihrp_pkg::REC_TYPE_EOF);
        else if (r < 90) rec_bytes.push_back(8'($urandom_range(2, 5)));
        else rec_bytes.push_back(8'($urandom_range(0, 255)));
        repeat (len) rec_bytes.push_back(8'($urandom_range(0, 255)));
        csum = 8'd0;
        foreach (rec_bytes[i]) csum = csum + rec_bytes[i];
        if ($urandom_range(0, 99) < 85) rec_bytes.push_back(8'd0 - csum);
        else rec_bytes.push_back(8'($urandom_range(0, 255)));

        chars.push_back(ihrp_pkg::COLON_CHAR);
        foreach (rec_bytes[i]) begin
            chars.push_back(hex_char(rec_bytes[i][7:4]));
            chars.push_back(hex_char(rec_bytes[i][3:0]));
        end
        if ($urandom_range(0, 29) == 0) begin
            chars[$urandom_range(1, chars.size() - 1)] = 8'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 19) == 0) begin
            chars = chars[0:$urandom_range(1, chars.size() - 2)];
        end
        foreach (chars[i]) send_char(chars[i], 1'b0, '0);
        record_chars += chars.size();
    endtask

    // Sink side: check each word taken, drive ready with random stalls,
    // and watch for a hang.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected");
                mismatch_count++;
            end else begin
                check_field("data_valid", 16'(pending_results[0].data_valid), 16'(m_data_valid));
                check_field("data_byte", 16'(pending_results[0].data_byte), 16'(m_data_byte));
                check_field("data_index", 16'(pending_results[0].data_index),
                            16'(m_data_index));
                check_field("record_done", 16'(pending_results[0].record_done),
                            16'(m_record_done));
                check_field("end_of_file", 16'(pending_results[0].end_of_file),
                            16'(m_end_of_file));
                check_field("checksum_ok", 16'(pending_results[0].checksum_ok),
                            16'(m_checksum_ok));
                check_field("rec_length", 16'(pending_results[0].rec_length),
                            16'(m_rec_length));
                check_field("load_address", pending_results[0].load_address, m_load_address);
                check_field("rec_type", 16'(pending_results[0].rec_type), 16'(m_rec_type));
                void'(pending_results.pop_front());
            end
        end

        // Hold ready low through a stall, else roll for a new one.
        if (sink_stall_left > 0) begin
            sink_stall_left--;
            m_ready <= 1'b0;
        end else begin
            sink_stall_left = pick_gap();
            if (sink_stall_left > 0) begin
                sink_stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end

        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        // Directed table: idle noise, the end-of-file record (zero byte count),
        // a colon straight after a finished record, lowercase digits, an
        // address of all ones, a non-hex data digit and a non-hex checksum.
        directed_rows = '{
            '{"Z", 1'b1, IDLE_WORD},
            '{":", 1'b1, IDLE_WORD},
            '{"0", 1'b0, '0}, '{"0", 1'b0, '0}, '{"0", 1'b0, '0}, '{"0", 1'b0, '0},
            '{"0", 1'b0, '0}, '{"0", 1'b0, '0}, '{"0", 1'b0, '0}, '{"1", 1'b0, '0},
            '{"F", 1'b0, '0},
            '{"F", 1'b1, EOF_WORD},
            '{":", 1'b1, IDLE_WORD},
            '{"0", 1'b0, '0}, '{"1", 1'b0, '0}, '{"f", 1'b0, '0}, '{"f", 1'b0, '0},
            '{"F", 1'b0, '0}, '{"F", 1'b0, '0}, '{"0", 1'b0, '0}, '{"0", 1'b0, '0},
            '{"g", 1'b0, '0},
            '{"5", 1'b1, BYTE_WORD},
            '{"x", 1'b0, '0},
            '{"x", 1'b1, BAD_SUM_WORD}
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_char(directed_rows[i].ch, directed_rows[i].fixed, directed_rows[i].want);
        end

        // Random records with stray characters between them; now and then
        // run a record with no gaps or stalls at all.
        while (record_chars < RECORD_CHAR_TARGET) begin
            quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1) == 0) begin
                repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(0, 255)), 1'b0, '0);
            end
            send_record();
        end
        quiet = 1'b0;
        s_valid <= 1'b0;

        // Drain, then linger for DRAIN_CYCLES in case the block misbehaves.
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/ihrp_pkg.sv
design/ihrp_core.sv
design/intel_hex_record_parser_unit.sv
tb/intel_hex_record_parser_unit_test.sv
